>>> rtl/lmsab_pkg.sv
// Shared constants, types and helpers of the LMS adaptive baseline filter.
package lmsab_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 32;
	localparam int WIN_BITS    = 6;
	localparam int TAP_BITS    = 5;
	localparam int AGE_BITS    = 6;
	localparam int HALF_BITS   = 5;
	localparam int LINE_DEPTH  = 64;
	localparam int CNT_BITS    = 7;
	localparam int POS_DEPTH   = 17;
	localparam int POS_BITS    = 32;
	localparam int WEIGHT_BITS = 40;
	localparam int W_FRAC      = 24;
	localparam int UPD_SHIFT   = 22;
	localparam int STEP_BITS   = 17;
	localparam int SUM_BITS    = 22;
	localparam int DIV_BITS    = 21;
	localparam int DIV_CNT     = 5;
	localparam int REF_BITS    = 18;
	localparam int EM_BITS     = 36;
	localparam int PROD_BITS   = 56;
	localparam int ACC_BITS    = 64;

	localparam logic [STEP_BITS-1:0] STEP_ONE = 17'h10000;

	typedef enum logic [1:0] {
		OP_SUM,
		OP_REF,
		OP_DOT,
		OP_UPD
	} op_t;

	typedef struct packed {
		logic                 load;
		logic                 rd_en;
		op_t                  op;
		logic [AGE_BITS-1:0]  age;
		logic [TAP_BITS-1:0]  tap;
		logic                 div_start;
		logic                 calc_err;
		logic                 calc_em;
		logic                 out_load;
		logic                 out_last;
		logic [HALF_BITS-1:0] pos_age;
		logic                 clear;
		logic [WIN_BITS-1:0]  win;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

	function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] v);
		logic [WIN_BITS-1:0] r;
		if (v == '0) begin
			r = WIN_BITS'(1);
		end else if (v > WIN_BITS'(MAX_WINDOW)) begin
			r = WIN_BITS'(MAX_WINDOW);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/lmsab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmsab_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/lmsab_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
module lmsab_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lmsab_pkg::DIV_BITS-1:0] dividend,
	input  logic [lmsab_pkg::WIN_BITS-1:0] divisor,
	output logic                          done,
	output logic [lmsab_pkg::DIV_BITS-1:0] quotient
);
	import lmsab_pkg::*;

	logic [WIN_BITS-1:0] rem_q;
	logic [WIN_BITS-1:0] dvs_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DIV_CNT-1:0]  cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [WIN_BITS:0]   trial;
	logic                fits;

	assign trial    = {rem_q, quo_q[DIV_BITS-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT'(1);
				if (cnt_q == DIV_CNT'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? WIN_BITS'(trial - {1'b0, dvs_q}) : trial[WIN_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end
endmodule

>>> rtl/lmsab_ctrl.sv
// Sequencer: per-sample iteration list, tap scans and phase order.
module lmsab_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          last,
	input  logic [lmsab_pkg::WIN_BITS-1:0] window,
	input  lmsab_pkg::status_t            status,
	output logic                          busy,
	output lmsab_pkg::cmd_t               cmd
);
	import lmsab_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEXT,
		S_SCAN,
		S_DRAIN,
		S_DIV,
		S_ERR,
		S_EM,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [WIN_BITS-1:0]  w_q;
	logic [HALF_BITS-1:0] h_q;
	logic [WIN_BITS-1:0]  seen_q;
	logic                 main_q;
	logic                 mean_q;
	logic                 last_q;
	logic [HALF_BITS-1:0] fl_q;
	logic [HALF_BITS-1:0] age_q;
	logic                 olast_q;
	op_t                  op_q;
	logic [TAP_BITS-1:0]  j_q;
	logic [WIN_BITS-1:0]  n_q;
	logic [HALF_BITS-1:0] base_q;
	logic [1:0]           dr_q;

	logic [WIN_BITS-1:0]  w_new;
	logic [HALF_BITS-1:0] h_new;
	logic [WIN_BITS:0]    kp1;
	logic [HALF_BITS-1:0] flush_new;
	logic                 accept;

	assign accept    = (state_q == S_IDLE) && in_valid;
	assign busy      = state_q != S_IDLE;
	assign w_new     = eff_window(window);
	assign h_new     = HALF_BITS'(w_new >> 1);
	assign kp1       = {1'b0, seen_q} + (WIN_BITS+1)'(1);
	assign flush_new = (kp1 < (WIN_BITS+1)'(h_new)) ? HALF_BITS'(kp1) : h_new;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.rd_en     = state_q == S_SCAN;
		cmd.op        = op_q;
		cmd.age       = AGE_BITS'({1'b0, base_q} + {1'b0, j_q});
		cmd.tap       = j_q;
		cmd.div_start = (state_q == S_DRAIN) && (dr_q == 2'd2) && (op_q == OP_SUM);
		cmd.calc_err  = state_q == S_ERR;
		cmd.calc_em   = state_q == S_EM;
		cmd.out_load  = (state_q == S_OUT) && status.out_free;
		cmd.out_last  = olast_q;
		cmd.pos_age   = age_q;
		cmd.clear     = (state_q == S_NEXT) && !main_q && (fl_q == '0) && last_q;
		cmd.win       = w_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= WIN_BITS'(1);
			h_q     <= '0;
			seen_q  <= '0;
			main_q  <= 1'b0;
			mean_q  <= 1'b0;
			last_q  <= 1'b0;
			fl_q    <= '0;
			age_q   <= '0;
			olast_q <= 1'b0;
			op_q    <= OP_REF;
			j_q     <= '0;
			n_q     <= WIN_BITS'(1);
			base_q  <= '0;
			dr_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						w_q    <= w_new;
						h_q    <= h_new;
						last_q <= last;
						main_q <= seen_q >= WIN_BITS'(h_new);
						mean_q <= seen_q >= {h_new, 1'b0};
						fl_q   <= last ? flush_new : '0;
						if (last) begin
							seen_q <= '0;
						end else if (seen_q < WIN_BITS'(MAX_WINDOW)) begin
							seen_q <= seen_q + WIN_BITS'(1);
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					j_q  <= '0;
					dr_q <= '0;
					if (main_q) begin
						main_q  <= 1'b0;
						age_q   <= h_q;
						olast_q <= last_q && (fl_q == '0);
						state_q <= S_SCAN;
						if (mean_q) begin
							op_q   <= OP_SUM;
							n_q    <= w_q;
							base_q <= '0;
						end else begin
							op_q   <= OP_REF;
							n_q    <= WIN_BITS'(1);
							base_q <= h_q;
						end
					end else if (fl_q != '0) begin
						// flush: raw sample serves as reference
						age_q   <= fl_q - HALF_BITS'(1);
						base_q  <= fl_q - HALF_BITS'(1);
						olast_q <= fl_q == HALF_BITS'(1);
						fl_q    <= fl_q - HALF_BITS'(1);
						op_q    <= OP_REF;
						n_q     <= WIN_BITS'(1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if ({1'b0, j_q} == n_q - WIN_BITS'(1)) begin
						dr_q    <= '0;
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + TAP_BITS'(1);
					end
				end
				S_DRAIN: begin
					dr_q <= dr_q + 2'd1;
					if (dr_q == 2'd2) begin
						j_q <= '0;
						case (op_q)
							OP_SUM: state_q <= S_DIV;
							OP_REF: begin
								op_q    <= OP_DOT;
								n_q     <= w_q;
								base_q  <= age_q;
								state_q <= S_SCAN;
							end
							OP_DOT:  state_q <= S_ERR;
							OP_UPD:  state_q <= S_OUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (status.div_done) begin
						op_q    <= OP_DOT;
						n_q     <= w_q;
						base_q  <= age_q;
						j_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_ERR: state_q <= S_EM;
				S_EM: begin
					op_q    <= OP_UPD;
					n_q     <= w_q;
					base_q  <= age_q;
					j_q     <= '0;
					state_q <= S_SCAN;
				end
				S_OUT: begin
					if (status.out_free) begin
						state_q <= S_NEXT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/lmsab_dp.sv
// Datapath: sample ring, weights, MAC pipeline, mean divider, output register.
module lmsab_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lmsab_pkg::cmd_t                     cmd,
	input  logic [lmsab_pkg::STEP_BITS-1:0]     step,
	input  logic signed [lmsab_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [lmsab_pkg::POS_BITS-1:0]      position,
	input  logic                                out_stall,
	output lmsab_pkg::status_t                  status,
	output logic                                out_valid,
	output logic signed [lmsab_pkg::SAMPLE_BITS-1:0] filtered_sample,
	output logic [lmsab_pkg::POS_BITS-1:0]      position_res,
	output logic                                last_res
);
	import lmsab_pkg::*;

	localparam logic signed [ACC_BITS-1:0] Y_MAX = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(1);
	localparam logic signed [WEIGHT_BITS:0] W_MAX = {2'b00, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS:0] W_MIN = {2'b11, {(WEIGHT_BITS-1){1'b0}}};
	localparam int LA = $clog2(LINE_DEPTH);

	logic [LA-1:0]       wptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [POS_BITS-1:0] pos_q [POS_DEPTH];
	logic signed [WEIGHT_BITS-1:0] wt_q [MAX_WINDOW];
	logic [LA-1:0]       raddr;
	logic [SAMPLE_BITS-1:0] rdata;

	logic                 rd_s1, vld_s1;
	op_t                  op_s1;
	logic [TAP_BITS-1:0]  tap_s1;
	logic                 rd_s2;
	op_t                  op_s2;
	logic [TAP_BITS-1:0]  tap_s2;
	logic signed [PROD_BITS-1:0] prod_s2;

	logic signed [SAMPLE_BITS-1:0] x;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [REF_BITS-1:0]    ref_q;
	logic signed [REF_BITS-1:0]    e_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [EM_BITS-1:0]     em_q;
	logic                          neg_q;

	logic [SUM_BITS-1:0]           sum_mag;
	logic                          div_done;
	logic [DIV_BITS-1:0]           quo;
	logic signed [ACC_BITS-1:0]    y_full;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic [STEP_BITS-1:0]          mu;
	logic signed [PROD_BITS-1:0]   p_rnd;
	logic signed [WEIGHT_BITS:0]   nw;

	assign raddr   = wptr_q - LA'(1) - LA'(cmd.age);
	assign x       = vld_s1 ? $signed(rdata) : '0;
	assign sum_mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
	assign mu      = (step > STEP_ONE) ? STEP_ONE : step;
	assign y_full  = (acc_q + ACC_BITS'(1 << (W_FRAC - 1))) >>> W_FRAC;
	assign y_sat   = (y_full > Y_MAX) ? SAMPLE_BITS'(Y_MAX) :
	                 (y_full < Y_MIN) ? SAMPLE_BITS'(Y_MIN) : y_full[SAMPLE_BITS-1:0];
	assign p_rnd   = (prod_s2 + PROD_BITS'(1 << (UPD_SHIFT - 1))) >>> UPD_SHIFT;
	assign nw      = (WEIGHT_BITS+1)'(wt_q[tap_s2]) + (WEIGHT_BITS+1)'(p_rnd);

	assign status.div_done = div_done;
	assign status.out_free = !out_valid || !out_stall;

	lmsab_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (wptr_q),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	lmsab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag[DIV_BITS-1:0]),
		.divisor  (cmd.win),
		.done     (div_done),
		.quotient (quo)
	);

	// control state: ring pointer, fill count, pipeline valids, weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			cnt_q     <= '0;
			rd_s1     <= 1'b0;
			rd_s2     <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < POS_DEPTH; i++) pos_q[i] <= '0;
			for (int i = 0; i < MAX_WINDOW; i++) wt_q[i] <= '0;
		end else begin
			rd_s1 <= cmd.rd_en;
			rd_s2 <= rd_s1;
			if (cmd.load) begin
				wptr_q <= wptr_q + LA'(1);
				if (cnt_q != CNT_BITS'(LINE_DEPTH)) cnt_q <= cnt_q + CNT_BITS'(1);
				pos_q[0] <= position;
				for (int i = 1; i < POS_DEPTH; i++) pos_q[i] <= pos_q[i-1];
			end
			if (rd_s2 && op_s2 == OP_UPD) begin
				wt_q[tap_s2] <= (nw > W_MAX) ? WEIGHT_BITS'(W_MAX) :
				                (nw < W_MIN) ? WEIGHT_BITS'(W_MIN) : nw[WEIGHT_BITS-1:0];
			end
			if (cmd.clear) begin
				cnt_q <= '0;
				for (int i = 0; i < POS_DEPTH; i++) pos_q[i] <= '0;
				for (int i = 0; i < MAX_WINDOW; i++) wt_q[i] <= '0;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		op_s1  <= cmd.op;
		tap_s1 <= cmd.tap;
		vld_s1 <= {1'b0, cmd.age} < cnt_q;
		op_s2  <= op_s1;
		tap_s2 <= tap_s1;
		if (op_s1 == OP_DOT) begin
			prod_s2 <= PROD_BITS'(wt_q[tap_s1] * x);
		end else begin
			prod_s2 <= PROD_BITS'(em_q * x);
		end
		if (rd_s1 && op_s1 == OP_SUM) begin
			sum_q <= (tap_s1 == '0) ? SUM_BITS'(x) : sum_q + SUM_BITS'(x);
		end
		if (rd_s1 && op_s1 == OP_REF) begin
			ref_q <= REF_BITS'(x);
		end
		if (rd_s2 && op_s2 == OP_DOT) begin
			acc_q <= (tap_s2 == '0) ? ACC_BITS'(prod_s2) : acc_q + ACC_BITS'(prod_s2);
		end
		if (cmd.div_start) begin
			neg_q <= sum_q[SUM_BITS-1];
		end
		if (div_done) begin
			ref_q <= neg_q ? -REF_BITS'(quo) : REF_BITS'(quo);
		end
		if (cmd.calc_err) begin
			y_q <= y_sat;
			e_q <= ref_q - REF_BITS'(y_sat);
		end
		if (cmd.calc_em) begin
			em_q <= EM_BITS'(e_q * $signed({1'b0, mu}));
		end
		if (cmd.out_load) begin
			filtered_sample <= y_q;
			position_res    <= pos_q[cmd.pos_age];
			last_res        <= cmd.out_last;
		end
	end
endmodule

>>> rtl/lms_adaptive_baseline_filter_unit.sv
// Top level of the LMS adaptive baseline filter: config registers and wiring.
//
//   channel   direction  handshake                      payload
//   input     in         in_valid / in_stall            sample, position, last
//   output    out        out_valid / out_stall          filtered_sample, position_res, last_res
//   config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An output iteration with the window mean as reference (W = effective window)
// runs a scan over the W window samples of the sample RAM for the window sum,
// the divider for the mean, then dot product and weight update scans, each
// scan followed by a drain, all through the single read port of the sample
// RAM. An iteration whose reference is the raw sample (early outputs and
// flush) reads that sample in a one-tap scan in place of the sum and divider.
// A transaction yields up to 1 + W/2 outputs.
// Reset needs no clearing pass: a fill count masks stale samples and the
// weights clear at once. in_stall is high whenever a transaction is in work;
// an output stalled by out_stall holds its register and delays the iteration.
module lms_adaptive_baseline_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lmsab_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [lmsab_pkg::POS_BITS-1:0]      position,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lmsab_pkg::SAMPLE_BITS-1:0] filtered_sample,
	output logic [lmsab_pkg::POS_BITS-1:0]      position_res,
	output logic                                last_res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import lmsab_pkg::*;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_STEP   = 1'b1;

	logic [WIN_BITS-1:0]  window_q;
	logic [STEP_BITS-1:0] step_q;
	cmd_t                 cmd;
	status_t              status;

	assign pready = 1'b1;

	// register file: word index is paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_BITS'(15);
			step_q   <= STEP_BITS'(655);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WINDOW: window_q <= pwdata[WIN_BITS-1:0];
				REG_STEP:   step_q   <= pwdata[STEP_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW: prdata = {{(32-WIN_BITS){1'b0}}, window_q};
			REG_STEP:   prdata = {{(32-STEP_BITS){1'b0}}, step_q};
			default:    prdata = '0;
		endcase
	end

	lmsab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.window   (window_q),
		.status   (status),
		.busy     (in_stall),
		.cmd      (cmd)
	);

	lmsab_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.step            (step_q),
		.sample          (sample),
		.position        (position),
		.out_stall       (out_stall),
		.status          (status),
		.out_valid       (out_valid),
		.filtered_sample (filtered_sample),
		.position_res    (position_res),
		.last_res        (last_res)
	);
endmodule

>>> rtl/lmsab_checker.sv
// Port-level checks of the filter unit, bound to the top level.
module lmsab_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [lmsab_pkg::SAMPLE_BITS-1:0] filtered_sample,
	input logic [lmsab_pkg::POS_BITS-1:0]      position_res,
	input logic                                last_res
);
	// an output held by stall keeps valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_sample)
		&& $stable(position_res) && $stable(last_res))
		else $error("stalled output changed");

	// an accepted transaction keeps the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// results only appear while a transaction is in work
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_stall)
		else $error("output raised while idle");
endmodule

bind lms_adaptive_baseline_filter_unit lmsab_checker u_chk (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the LMS adaptive baseline filter unit.
`timescale 1ns / 100ps

module tb_top;
	import lmsab_pkg::*;

	localparam int LINE_LEN  = 48;
	localparam int LIMIT_CYC = 10000000;
	localparam logic [2:0] ADDR_WINDOW = 3'd0;
	localparam logic [2:0] ADDR_STEP   = 3'd4;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [POS_BITS-1:0]           pos;
		logic                          lst;
	} ecg_item_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] y;
		logic [POS_BITS-1:0]           pos;
		logic                          lst;
	} filt_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic [POS_BITS-1:0] position = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] filtered_sample;
	logic [POS_BITS-1:0] position_res;
	logic last_res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lms_adaptive_baseline_filter_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// filter model state
	logic [5:0]  win_reg;
	logic [16:0] step_reg;
	int          sline [LINE_LEN];
	longint      wts [MAX_WINDOW];
	logic [31:0] pdelay [POS_DEPTH];
	int          seen;

	ecg_item_t pend_q[$];
	filt_out_t filt_q[$];
	ecg_item_t cur;
	int errors = 0;
	int accepted = 0;
	int results = 0;
	int records = 0;
	int cycles = 0;

	function automatic void clear_filter();
		foreach (sline[i]) sline[i] = 0;
		foreach (wts[i]) wts[i] = 0;
		foreach (pdelay[i]) pdelay[i] = '0;
		seen = 0;
	endfunction

	// one LMS iteration; newest tap is the sample at age 'age'
	function automatic longint lms_adapt(int age, int w, longint dref);
		longint acc, y, e, mu, p, nw;
		acc = 0;
		mu = (step_reg > STEP_ONE) ? 65536 : longint'(step_reg);
		for (int j = 0; j < w; j++) acc += wts[j] * longint'(sline[age + j]);
		y = (acc + (64'sd1 << (W_FRAC - 1))) >>> W_FRAC;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		e = dref - y;
		for (int j = 0; j < w; j++) begin
			p = e * longint'(sline[age + j]) * mu + (64'sd1 << (UPD_SHIFT - 1));
			nw = wts[j] + (p >>> UPD_SHIFT);
			if (nw > 64'sd549755813887) nw = 64'sd549755813887;
			if (nw < -64'sd549755813888) nw = -64'sd549755813888;
			wts[j] = nw;
		end
		return y;
	endfunction

	function automatic void predict_filter(ecg_item_t it);
		int w, h, k, flush;
		longint dref, sum;
		filt_out_t r;
		w = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
		h = w / 2;
		k = seen;
		flush = 0;
		for (int i = LINE_LEN - 1; i > 0; i--) sline[i] = sline[i-1];
		sline[0] = int'(it.smp);
		for (int i = POS_DEPTH - 1; i > 0; i--) pdelay[i] = pdelay[i-1];
		pdelay[0] = it.pos;
		if (it.lst) flush = (k + 1 < h) ? k + 1 : h;
		if (k >= h) begin
			if (k >= 2 * h) begin
				sum = 0;
				for (int j = 0; j < w; j++) sum += sline[j];
				dref = sum / w;
			end else begin
				dref = sline[h];
			end
			r.y = SAMPLE_BITS'(lms_adapt(h, w, dref));
			r.pos = pdelay[h];
			r.lst = it.lst && flush == 0;
			filt_q = {filt_q, r};
		end
		if (it.lst) begin
			for (int a = flush; a > 0; a--) begin
				r.y = SAMPLE_BITS'(lms_adapt(a - 1, w, sline[a-1]));
				r.pos = pdelay[a-1];
				r.lst = (a == 1);
				filt_q = {filt_q, r};
			end
			clear_filter();
			records++;
		end else if (k < MAX_WINDOW) begin
			seen = k + 1;
		end
	endfunction

	// driver: bursts of random length, random gaps; payload holds while stalled
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_filter(cur);
				accepted++;
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				cur = pend_q.pop_front();
				in_valid <= 1'b1;
				sample <= cur.smp;
				position <= cur.pos;
				last <= cur.lst;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
						: $urandom_range(0, 2);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: modes of none, light and heavy stalling
	int stall_mode = 0;
	int stall_phase = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("tb_top: errors");
			$finish;
		end
		stall_phase = (stall_phase + 1) % 97;
		if (stall_phase == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// monitor: compare each accepted output transaction with the oldest prediction
	always @(posedge clk) begin
		filt_out_t ex;
		if (arst_n && out_valid && !out_stall) begin
			results++;
			if (filt_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output y=%0d pos=%h last=%b",
						filtered_sample, position_res, last_res);
			end else begin
				ex = filt_q.pop_front();
				if (ex.y !== filtered_sample || ex.pos !== position_res ||
				    ex.lst !== last_res) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp y=%0d pos=%h last=%b, got y=%0d pos=%h last=%b",
							ex.y, ex.pos, ex.lst, filtered_sample, position_res, last_res);
				end
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW) win_reg = data[5:0];
		else step_reg = data[16:0];
	endtask

	// wait until all traffic is drained, then let flush work settle
	task automatic drain_all();
		do @(posedge clk); while (pend_q.size() > 0 || in_valid || filt_q.size() > 0);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 4000) - 2000);
			default: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
		endcase
	endfunction

	function automatic void queue_record(int n, int kind, bit term);
		ecg_item_t it;
		for (int i = 0; i < n; i++) begin
			it.smp = rand_sample(kind);
			it.pos = $urandom;
			it.lst = term && (i == n - 1);
			pend_q = {pend_q, it};
		end
	endfunction

	function automatic void queue_one(logic signed [15:0] s, logic [31:0] p, logic l);
		ecg_item_t it;
		it.smp = s;
		it.pos = p;
		it.lst = l;
		pend_q = {pend_q, it};
	endfunction

	initial begin
		int wsel [10] = '{0, 1, 2, 32, 63, 33, 15, 7, 16, 24};
		int ssel [10] = '{65536, 1, 131071, 0, 65536, 655, 40000, 3000, 100000, 12000};
		win_reg = 6'd15;
		step_reg = 17'd655;
		clear_filter();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, records shorter than the delay, full record
		queue_one(16'sh7fff, 32'hffffffff, 1'b1);
		queue_one(-16'sh8000, 32'h0, 1'b0);
		queue_one(16'sh0, 32'h1, 1'b0);
		queue_one(16'sh7fff, 32'h80000000, 1'b1);
		for (int i = 0; i < 20; i++)
			queue_one(i[0] ? -16'sh8000 : 16'sh7fff, 32'(i) ^ 32'h5555aaaa, i == 19);
		drain_all();

		// random phases over window and step settings, extremes first
		for (int ph = 0; ph < 10; ph++) begin
			apb_write(ADDR_WINDOW, {26'($urandom_range(0, 67108863)), 6'(wsel[ph])});
			apb_write(ADDR_STEP, {15'($urandom), 17'(ssel[ph])});
			for (int n = 0; n < 27; ) begin
				int len;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 50);
				queue_record(len, $urandom_range(0, 2), $urandom_range(0, 4) != 0);
				n += len;
			end
			drain_all();
		end

		$display("run covered %0d input and %0d output transactions, %0d records",
			accepted, results, records);
		$display("window and step swept over extremes and %0d settings", 10);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("mismatches: %0d", errors);
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
